// ===== hdl/capture_pair_frequency_meter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the capture pair frequency meter
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef CAPTURE_PAIR_FREQUENCY_METER_MACROS_SVH
`define CAPTURE_PAIR_FREQUENCY_METER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPFM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define CPFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in next-cycle check");

`endif

// ===== hdl/cpfm_pkg.sv =====
// ----------------------------------------------------------------------------
// Capture pair frequency meter package
// Field widths, register indexes, reset values and the command and status
// types that join the controller and the datapath.
// ----------------------------------------------------------------------------
package cpfm_pkg;

    localparam int COUNTER_BITS_DEFAULT = 16;

    localparam int TICK_W  = 24;
    localparam int STEP_W  = 16;
    localparam int FREQ_W  = 16;
    localparam int ROUND_W = 17;
    localparam int NUM_W   = TICK_W;
    localparam int IDX_W   = 8;

    localparam logic [TICK_W-1:0] TICK_RATE_RESET  = 24'd1000000;
    localparam logic [STEP_W-1:0] ROUND_STEP_RESET = 16'd1000;
    localparam logic [FREQ_W-1:0] FREQ_MAX         = 16'hFFFF;

    localparam logic [IDX_W-1:0] REG_TICK_RATE  = 8'd0;
    localparam logic [IDX_W-1:0] REG_ROUND_STEP = 8'd1;

    typedef struct packed {
        logic store_first;
        logic load_period;
        logic div_start;
        logic div_short;
        logic take_freq;
        logic take_round;
        logic load_out;
    } cpfm_cmd_t;

    typedef struct packed {
        logic period_zero;
        logic round_needed;
        logic div_done;
    } cpfm_status_t;

endpackage

// ===== hdl/cpfm_interfaces.sv =====
// ----------------------------------------------------------------------------
// Capture pair frequency meter channel interfaces
// Valid/ready channels for captures, results and register writes.
// ----------------------------------------------------------------------------
interface cpfm_capture_if #(
    parameter int COUNTER_BITS = cpfm_pkg::COUNTER_BITS_DEFAULT
);
    logic                    valid;
    logic                    ready;
    logic [COUNTER_BITS-1:0] capture_value;

    modport source (output valid, output capture_value, input ready);
    modport sink   (input valid, input capture_value, output ready);
endinterface

interface cpfm_result_if;
    logic                          valid;
    logic                          ready;
    logic [cpfm_pkg::FREQ_W-1:0]   freq_hz;
    logic [cpfm_pkg::ROUND_W-1:0]  freq_rounded;
    logic [cpfm_pkg::FREQ_W-1:0]   period_ticks;
    logic                          zero_period;
    logic                          saturated;

    modport source (output valid, output freq_hz, output freq_rounded,
                    output period_ticks, output zero_period, output saturated,
                    input ready);
    modport sink   (input valid, input freq_hz, input freq_rounded,
                    input period_ticks, input zero_period, input saturated,
                    output ready);
endinterface

interface cpfm_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [cpfm_pkg::IDX_W-1:0]   index;
    logic [cpfm_pkg::TICK_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/cpfm_divider.sv =====
// ----------------------------------------------------------------------------
// Capture pair frequency meter divider
// Restoring divider that produces one quotient bit per cycle. A short run
// handles a numerator whose value sits in the upper bits.
// ----------------------------------------------------------------------------
`include "capture_pair_frequency_meter_macros.svh"

module cpfm_divider #(
    parameter int NUM_W       = cpfm_pkg::NUM_W,
    parameter int DEN_W       = cpfm_pkg::COUNTER_BITS_DEFAULT,
    parameter int SHORT_STEPS = cpfm_pkg::FREQ_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             short_run,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quotient,
    output logic [DEN_W-1:0] remainder,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;

    always_comb
    begin
        shifted = {rem_reg, quot_reg[NUM_W-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = shifted >= {1'b0, den_reg};
        rem_next  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        quot_next = {quot_reg[NUM_W-2:0], fits};
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = short_run ? CNT_W'(SHORT_STEPS) : CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (cnt_reg != '0)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign quotient  = quot_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

    `CPFM_ASSERT_NEXT(a_done_after_last_step, clk, rst_n, (cnt_reg == CNT_W'(1)) && !start, done_reg)
    `CPFM_ASSERT_IMPL(a_no_start_while_busy, clk, rst_n, start, (cnt_reg == '0))

endmodule

// ===== hdl/cpfm_datapath.sv =====
// ----------------------------------------------------------------------------
// Capture pair frequency meter datapath
// Configuration registers, pair period arithmetic, the shared divider, the
// saturation and rounding logic and the result register.
// ----------------------------------------------------------------------------
module cpfm_datapath #(
    parameter int COUNTER_BITS = cpfm_pkg::COUNTER_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cpfm_pkg::cpfm_cmd_t             cmd,
    output cpfm_pkg::cpfm_status_t          status,
    input  logic [COUNTER_BITS-1:0]         capture_value,
    input  logic                            cfg_we,
    input  logic [cpfm_pkg::IDX_W-1:0]      cfg_index,
    input  logic [cpfm_pkg::TICK_W-1:0]     cfg_data,
    output logic [cpfm_pkg::FREQ_W-1:0]     freq_hz,
    output logic [cpfm_pkg::ROUND_W-1:0]    freq_rounded,
    output logic [cpfm_pkg::FREQ_W-1:0]     period_ticks,
    output logic                            zero_period,
    output logic                            saturated
);

    localparam int W     = COUNTER_BITS;
    localparam int DEN_W = (COUNTER_BITS > cpfm_pkg::STEP_W) ? COUNTER_BITS : cpfm_pkg::STEP_W;
    localparam int NUM_W = cpfm_pkg::NUM_W;
    localparam int FW    = cpfm_pkg::FREQ_W;
    localparam int RW    = cpfm_pkg::ROUND_W;
    localparam int SW    = cpfm_pkg::STEP_W;

    logic [cpfm_pkg::TICK_W-1:0] tick_reg;
    logic [SW-1:0]               step_reg;
    logic [W-1:0]                first_reg;
    logic [W-1:0]                period_reg;
    logic [FW-1:0]               freq_reg;
    logic                        sat_reg;
    logic [RW-1:0]               rounded_reg;

    logic [FW-1:0]               out_freq_reg;
    logic [RW-1:0]               out_rounded_reg;
    logic [FW-1:0]               out_period_reg;
    logic                        out_zero_reg;
    logic                        out_sat_reg;

    logic [W-1:0]                cap_adj;
    logic [W-1:0]                period_calc;
    logic [NUM_W-1:0]            div_num;
    logic [DEN_W-1:0]            div_den;
    logic [NUM_W-1:0]            div_quot;
    logic [DEN_W-1:0]            div_rem;
    logic                        div_done;
    logic [SW-1:0]               rem_step;
    logic [RW-1:0]               rounded_down;
    logic [RW-1:0]               rounded_calc;
    logic                        quot_over;

    // Wrapping period between the stored capture and the adjusted second one.
    always_comb
    begin
        cap_adj     = capture_value + W'(1);
        period_calc = (cap_adj > first_reg) ? (cap_adj - first_reg) : (cap_adj + ~first_reg);
    end

    always_comb
    begin
        div_num = cmd.div_short ? {freq_reg, {(NUM_W - FW){1'b0}}} : NUM_W'(tick_reg);
        div_den = cmd.div_short ? DEN_W'(step_reg) : DEN_W'(period_reg);
    end

    cpfm_divider #(
        .NUM_W       (NUM_W),
        .DEN_W       (DEN_W),
        .SHORT_STEPS (FW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .short_run (cmd.div_short),
        .num       (div_num),
        .den       (div_den),
        .quotient  (div_quot),
        .remainder (div_rem),
        .done      (div_done)
    );

    always_comb
    begin
        quot_over    = (div_quot[NUM_W-1:FW] != '0);
        rem_step     = div_rem[SW-1:0];
        rounded_down = {1'b0, freq_reg} - {1'b0, rem_step};
        if ({rem_step, 1'b0} >= {1'b0, step_reg})
        begin
            rounded_calc = rounded_down + {1'b0, step_reg};
        end
        else
        begin
            rounded_calc = rounded_down;
        end
    end

    assign status.period_zero  = (period_reg == '0);
    assign status.round_needed = (step_reg != '0) && (freq_reg >= step_reg);
    assign status.div_done     = div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= cpfm_pkg::TICK_RATE_RESET;
            step_reg <= cpfm_pkg::ROUND_STEP_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == cpfm_pkg::REG_TICK_RATE)
            begin
                tick_reg <= cfg_data;
            end
            else if (cfg_index == cpfm_pkg::REG_ROUND_STEP)
            begin
                step_reg <= cfg_data[SW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
        end
        else if (cmd.store_first)
        begin
            first_reg <= capture_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_period)
        begin
            period_reg  <= period_calc;
            freq_reg    <= '0;
            sat_reg     <= 1'b0;
            rounded_reg <= '0;
        end
        else if (cmd.take_freq)
        begin
            freq_reg    <= quot_over ? cpfm_pkg::FREQ_MAX : div_quot[FW-1:0];
            sat_reg     <= quot_over;
            rounded_reg <= {1'b0, (quot_over ? cpfm_pkg::FREQ_MAX : div_quot[FW-1:0])};
        end
        else if (cmd.take_round)
        begin
            rounded_reg <= rounded_calc;
        end

        if (cmd.load_out)
        begin
            out_freq_reg    <= freq_reg;
            out_rounded_reg <= rounded_reg;
            out_period_reg  <= FW'(period_reg);
            out_zero_reg    <= (period_reg == '0);
            out_sat_reg     <= sat_reg;
        end
    end

    assign freq_hz      = out_freq_reg;
    assign freq_rounded = out_rounded_reg;
    assign period_ticks = out_period_reg;
    assign zero_period  = out_zero_reg;
    assign saturated    = out_sat_reg;

endmodule

// ===== hdl/cpfm_controller.sv =====
// ----------------------------------------------------------------------------
// Capture pair frequency meter controller
// Tracks the pair phase and sequences period, division, rounding and the
// hand-off of each result to the output register.
// ----------------------------------------------------------------------------
`include "capture_pair_frequency_meter_macros.svh"

module cpfm_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  cpfm_pkg::cpfm_status_t status,
    output cpfm_pkg::cpfm_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE         = 6'b000001,
        ST_CHECK_PERIOD = 6'b000010,
        ST_DIV_FREQ     = 6'b000100,
        ST_CHECK_ROUND  = 6'b001000,
        ST_DIV_ROUND    = 6'b010000,
        ST_OUTPUT       = 6'b100000
    } cpfm_state_t;

    cpfm_state_t state_reg, state_next;
    logic        phase_reg, phase_next;
    logic        out_valid_reg, out_valid_next;
    logic        accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!phase_reg)
                    begin
                        cmd.store_first = 1'b1;
                        phase_next      = 1'b1;
                    end
                    else
                    begin
                        cmd.load_period = 1'b1;
                        phase_next      = 1'b0;
                        state_next      = ST_CHECK_PERIOD;
                    end
                end
            end
            ST_CHECK_PERIOD:
            begin
                if (status.period_zero)
                begin
                    state_next = ST_OUTPUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_FREQ;
                end
            end
            ST_DIV_FREQ:
            begin
                if (status.div_done)
                begin
                    cmd.take_freq = 1'b1;
                    state_next    = ST_CHECK_ROUND;
                end
            end
            ST_CHECK_ROUND:
            begin
                if (status.round_needed)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_short = 1'b1;
                    state_next    = ST_DIV_ROUND;
                end
                else
                begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_DIV_ROUND:
            begin
                cmd.div_short = 1'b1;
                if (status.div_done)
                begin
                    cmd.take_round = 1'b1;
                    state_next     = ST_OUTPUT;
                end
            end
            ST_OUTPUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `CPFM_ASSERT_IMPL(a_no_result_overwrite, clk, rst_n, cmd.load_out, (!out_valid_reg || out_ready))
    `CPFM_ASSERT_NEXT(a_second_capture_starts, clk, rst_n, accept && phase_reg, (state_reg == ST_CHECK_PERIOD) && !phase_reg)
    `CPFM_ASSERT_NEXT(a_zero_period_skips_div, clk, rst_n, (state_reg == ST_CHECK_PERIOD) && status.period_zero, (state_reg == ST_OUTPUT))

endmodule

// ===== hdl/capture_pair_frequency_meter.sv =====
// After the second capture transaction of a pair, the controller runs the period check,
// the frequency division, the rounding check, the rounding division when needed and the
// output state; a zero period goes from the period check straight to the output state.
// The one-bit-per-cycle shared divider takes 24 steps for the frequency, 16 for rounding.
// A finished result waits in the output register while the next pair is captured.
// Reset (rst_n, asynchronous, active low) clears the pair phase and stored capture.
// ----------------------------------------------------------------------------
// Capture pair frequency meter
// Measures frequency from pairs of timer captures: the tick rate divided by
// the wrapping tick count between the two captures, saturated to 16 bits,
// with a copy rounded half up to a configurable step.
// ----------------------------------------------------------------------------
module capture_pair_frequency_meter #(
    parameter int COUNTER_BITS = cpfm_pkg::COUNTER_BITS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    cpfm_capture_if.sink   capture,
    cpfm_result_if.source  result,
    cpfm_cfg_if.sink       cfg
);

    // Command and status bundle between the sequencer and the datapath.
    cpfm_pkg::cpfm_cmd_t    cmd;
    cpfm_pkg::cpfm_status_t status;

    // Register writes are always taken; the user must issue them only while the
    // block is idle; no interlock with the sequencer enforces this.
    assign cfg.ready = 1'b1;

    // The controller owns the pair phase, the state sequence and the result
    // valid flag. Captures are taken only while it is idle; the first of a
    // pair is stored and the second starts the computation.
    cpfm_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (capture.valid),
        .in_ready  (capture.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the configuration, the stored first capture, the
    // period and the shared divider. The divider first computes
    // tick_rate_hz / period and later, when rounding applies, the remainder
    // of the frequency by the rounding step.
    cpfm_datapath #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .capture_value (capture.capture_value),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .freq_hz       (result.freq_hz),
        .freq_rounded  (result.freq_rounded),
        .period_ticks  (result.period_ticks),
        .zero_period   (result.zero_period),
        .saturated     (result.saturated)
    );

endmodule
